// ===== design/rgbhsv_pkg.sv =====
// shared types and constants for the rgb to hsv pixel converter
package rgbhsv_pkg;

    localparam int BYTE_W       = 8;
    localparam int NUM_W        = 11;
    localparam int NUM60_W      = 17;
    localparam int HUE_W        = 15;
    localparam int SAT_W        = 16;
    localparam int SAT_SHIFT    = 15;
    localparam int HUE_TURN_DEG = 360;
    localparam int QUEUE_DEPTH  = 4;
    localparam int QPTR_W       = 2;
    localparam int QCNT_W       = 3;

    typedef struct packed {
        logic [BYTE_W-1:0] brightness;
        logic [BYTE_W-1:0] spread;
        logic [NUM_W-1:0]  num;
    } t_task;

endpackage

// ===== design/rgbhsv_front.sv =====
// front end: pixel transfer, max/min search and hue numerator selection
module rgbhsv_front (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [rgbhsv_pkg::BYTE_W-1:0] i_red,
    input  logic [rgbhsv_pkg::BYTE_W-1:0] i_green,
    input  logic [rgbhsv_pkg::BYTE_W-1:0] i_blue,
    input  logic                      i_q_full,
    output logic                      o_busy,
    output logic                      o_push,
    output rgbhsv_pkg::t_task         o_task
);
    import rgbhsv_pkg::*;

    logic              r_valid;
    logic              n_valid;
    t_task             r_task;
    t_task             n_task;
    logic              w_accept;
    logic [BYTE_W-1:0] w_max_gb;
    logic [BYTE_W-1:0] w_min_gb;
    logic [BYTE_W-1:0] w_max;
    logic [BYTE_W-1:0] w_min;
    logic [BYTE_W-1:0] w_spread;

    assign o_busy   = r_valid && i_q_full;
    assign o_push   = r_valid && !i_q_full;
    assign o_task   = r_task;
    assign w_accept = i_start && !o_busy;

    always_comb begin
        w_max_gb = (i_green > i_blue) ? i_green : i_blue;
        w_min_gb = (i_green < i_blue) ? i_green : i_blue;
        w_max    = (i_red > w_max_gb) ? i_red : w_max_gb;
        w_min    = (i_red < w_min_gb) ? i_red : w_min_gb;
        w_spread = w_max - w_min;
        n_task.brightness = w_max;
        n_task.spread     = w_spread;
        // channel priority red, green, blue on a tied maximum
        if (w_max == i_red) begin
            n_task.num = NUM_W'(i_green) + NUM_W'({w_spread, 2'b00})
                       + NUM_W'({w_spread, 1'b0}) - NUM_W'(i_blue);
        end else if (w_max == i_green) begin
            n_task.num = NUM_W'(i_blue) + NUM_W'({w_spread, 1'b0}) - NUM_W'(i_red);
        end else begin
            n_task.num = NUM_W'(i_red) + NUM_W'({w_spread, 2'b00}) - NUM_W'(i_green);
        end
    end

    always_comb begin
        n_valid = r_valid;
        if (w_accept) begin
            n_valid = 1'b1;
        end else if (o_push) begin
            n_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_task <= n_task;
        end
    end

endmodule

// ===== design/rgbhsv_queue.sv =====
// short task queue between front and back ends
module rgbhsv_queue (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  rgbhsv_pkg::t_task i_task,
    input  logic              i_pop,
    output logic              o_valid,
    output logic              o_full,
    output rgbhsv_pkg::t_task o_task
);
    import rgbhsv_pkg::*;

    t_task             r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr;
    logic [QPTR_W-1:0] r_rd_ptr;
    logic [QCNT_W-1:0] r_count;
    logic [QCNT_W-1:0] n_count;
    logic              w_pop;

    assign o_valid = (r_count != '0);
    assign o_full  = (r_count == QCNT_W'(QUEUE_DEPTH));
    assign o_task  = r_mem[r_rd_ptr];
    assign w_pop   = i_pop && o_valid;

    always_comb begin
        n_count = r_count;
        if (i_push && !w_pop) begin
            n_count = r_count + 1'b1;
        end else if (!i_push && w_pop) begin
            n_count = r_count - 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_count <= n_count;
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_task;
        end
    end

endmodule

// ===== design/rgbhsv_div.sv =====
// pipelined restoring divider, one quotient bit per stage
module rgbhsv_div #(
    parameter int NUM_W = 23,
    parameter int DEN_W = 8,
    parameter int Q_W   = 16
) (
    input  logic             i_clk,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [Q_W-1:0]   o_quo
);

    logic [DEN_W-1:0] r_rem [Q_W];
    logic [DEN_W-1:0] r_den [Q_W];
    logic [Q_W-1:0]   r_low [Q_W];
    logic [Q_W-1:0]   r_quo [Q_W];

    assign o_quo = r_quo[Q_W-1];

    for (genvar s = 0; s < Q_W; s++) begin : g_stage
        logic [DEN_W-1:0] w_rem_in;
        logic [DEN_W-1:0] w_den_in;
        logic [Q_W-1:0]   w_low_in;
        logic [Q_W-1:0]   w_quo_in;
        logic [DEN_W:0]   w_try;
        logic             w_ge;

        if (s == 0) begin : g_first
            // upper numerator bits are known to stay below the divisor
            assign w_rem_in = DEN_W'(i_num[NUM_W-1:Q_W]);
            assign w_den_in = i_den;
            assign w_low_in = i_num[Q_W-1:0];
            assign w_quo_in = '0;
        end else begin : g_next
            assign w_rem_in = r_rem[s-1];
            assign w_den_in = r_den[s-1];
            assign w_low_in = r_low[s-1];
            assign w_quo_in = r_quo[s-1];
        end

        assign w_try = {w_rem_in, w_low_in[Q_W-1]};
        assign w_ge  = (w_try >= {1'b0, w_den_in});

        always_ff @(posedge i_clk) begin
            r_rem[s] <= w_ge ? DEN_W'(w_try - {1'b0, w_den_in}) : DEN_W'(w_try);
            r_den[s] <= w_den_in;
            r_low[s] <= {w_low_in[Q_W-2:0], 1'b0};
            r_quo[s] <= {w_quo_in[Q_W-2:0], w_ge};
        end
    end

endmodule

// ===== design/rgbhsv_back.sv =====
// back end: hue and saturation division, hue wrap and result register
module rgbhsv_back #(
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  rgbhsv_pkg::t_task             i_task,
    output logic                          o_done,
    output logic [rgbhsv_pkg::HUE_W-1:0]  o_hue,
    output logic [rgbhsv_pkg::SAT_W-1:0]  o_saturation,
    output logic [rgbhsv_pkg::BYTE_W-1:0] o_brightness
);
    import rgbhsv_pkg::*;

    localparam int DIV_W  = (9 + HUE_FRAC_BITS > SAT_W) ? 9 + HUE_FRAC_BITS : SAT_W;
    localparam int HNUM_W = NUM60_W + HUE_FRAC_BITS;
    localparam int SNUM_W = BYTE_W + SAT_SHIFT;
    localparam logic [DIV_W-1:0] HUE_TURN = DIV_W'(HUE_TURN_DEG << HUE_FRAC_BITS);

    logic [NUM60_W-1:0] w_num60;
    logic [HNUM_W-1:0]  w_hnum;
    logic [SNUM_W-1:0]  w_snum;
    logic [DIV_W-1:0]   w_hue_quo;
    logic [DIV_W-1:0]   w_sat_quo;
    logic [DIV_W-1:0]   w_hue_wrap;

    logic               r_vld   [DIV_W];
    logic               r_grey  [DIV_W];
    logic               r_black [DIV_W];
    logic [BYTE_W-1:0]  r_bri   [DIV_W];

    logic               r_done;
    logic [HUE_W-1:0]   r_hue;
    logic [SAT_W-1:0]   r_sat;
    logic [BYTE_W-1:0]  r_bri_out;

    // times 60 as 64 - 4
    assign w_num60 = NUM60_W'({i_task.num, 6'b0}) - NUM60_W'({i_task.num, 2'b0});
    assign w_hnum  = HNUM_W'(w_num60) << HUE_FRAC_BITS;
    assign w_snum  = SNUM_W'(i_task.spread) << SAT_SHIFT;

    rgbhsv_div #(
        .NUM_W (HNUM_W),
        .DEN_W (BYTE_W),
        .Q_W   (DIV_W)
    ) u_hue_div (
        .i_clk (i_clk),
        .i_num (w_hnum),
        .i_den (i_task.spread),
        .o_quo (w_hue_quo)
    );

    rgbhsv_div #(
        .NUM_W (SNUM_W),
        .DEN_W (BYTE_W),
        .Q_W   (DIV_W)
    ) u_sat_div (
        .i_clk (i_clk),
        .i_num (w_snum),
        .i_den (i_task.brightness),
        .o_quo (w_sat_quo)
    );

    for (genvar s = 0; s < DIV_W; s++) begin : g_side
        if (s == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else begin
                    r_vld[s] <= i_valid;
                end
            end
            always_ff @(posedge i_clk) begin
                r_grey[s]  <= (i_task.spread == '0);
                r_black[s] <= (i_task.brightness == '0);
                r_bri[s]   <= i_task.brightness;
            end
        end else begin : g_next
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_vld[s] <= 1'b0;
                end else begin
                    r_vld[s] <= r_vld[s-1];
                end
            end
            always_ff @(posedge i_clk) begin
                r_grey[s]  <= r_grey[s-1];
                r_black[s] <= r_black[s-1];
                r_bri[s]   <= r_bri[s-1];
            end
        end
    end

    // quotient stays below two turns, so one subtract wraps it
    assign w_hue_wrap = (w_hue_quo >= HUE_TURN) ? w_hue_quo - HUE_TURN : w_hue_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done <= 1'b0;
        end else begin
            r_done <= r_vld[DIV_W-1];
        end
    end

    always_ff @(posedge i_clk) begin
        r_hue     <= r_grey[DIV_W-1] ? '0 : HUE_W'(w_hue_wrap);
        r_sat     <= r_black[DIV_W-1] ? '0 : SAT_W'(w_sat_quo);
        r_bri_out <= r_bri[DIV_W-1];
    end

    assign o_done       = r_done;
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_brightness = r_bri_out;

endmodule

// ===== design/rgb_to_hsv_pixel.sv =====
// top level of the rgb to hsv pixel converter
//
//  channel   signals                                    transfer
//  pixel     start, busy, i_red, i_green, i_blue        start high and busy low
//  result    o_done, o_hue, o_saturation, o_brightness  o_done high, one cycle
//
// one pixel per clock sustained while busy is low; each result passes the front register,
// the queue, the two dividers that resolve one quotient bit per pipeline stage over
// DIV_W = max(16, 9 + HUE_FRAC_BITS) stages, and the result register.
// synchronous active-low reset clears the front register, queue and pipeline.
// the receiver cannot stall; busy rises only while the task queue is full.
module rgb_to_hsv_pixel #(
    parameter int HUE_FRAC_BITS = 6
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          start,
    output logic                          busy,
    input  logic [rgbhsv_pkg::BYTE_W-1:0] i_red,
    input  logic [rgbhsv_pkg::BYTE_W-1:0] i_green,
    input  logic [rgbhsv_pkg::BYTE_W-1:0] i_blue,
    output logic                          o_done,
    output logic [rgbhsv_pkg::HUE_W-1:0]  o_hue,
    output logic [rgbhsv_pkg::SAT_W-1:0]  o_saturation,
    output logic [rgbhsv_pkg::BYTE_W-1:0] o_brightness
);
    import rgbhsv_pkg::*;

    logic  w_push;
    logic  w_q_full;
    logic  w_q_valid;
    t_task w_front_task;
    t_task w_back_task;

    rgbhsv_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_red    (i_red),
        .i_green  (i_green),
        .i_blue   (i_blue),
        .i_q_full (w_q_full),
        .o_busy   (busy),
        .o_push   (w_push),
        .o_task   (w_front_task)
    );

    rgbhsv_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_task  (w_front_task),
        .i_pop   (w_q_valid),
        .o_valid (w_q_valid),
        .o_full  (w_q_full),
        .o_task  (w_back_task)
    );

    rgbhsv_back #(
        .HUE_FRAC_BITS (HUE_FRAC_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (w_q_valid),
        .i_task       (w_back_task),
        .o_done       (o_done),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

`ifndef SYNTHESIS
    a_sat_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> (o_saturation <= 16'd32768))
        else $error("saturation above one");

    a_black_pixel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (o_brightness == '0)) |-> ((o_saturation == '0) && (o_hue == '0)))
        else $error("black pixel with nonzero hue or saturation");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_done && (HUE_FRAC_BITS <= 6))
            |-> (32'(o_hue) < (32'(HUE_TURN_DEG) << HUE_FRAC_BITS)))
        else $error("hue not wrapped below a full turn");

    a_busy_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy |-> (w_q_full && !w_push))
        else $error("busy without a full queue");
`endif

endmodule

// ===== tb/tb_rgb_to_hsv_pixel.sv =====
// self-checking testbench for the rgb to hsv pixel converter, directed table then random pixels
module tb_rgb_to_hsv_pixel;

    import rgbhsv_pkg::*;

    localparam int HUE_FRAC    = 6;
    localparam int N_DIRECTED  = 21;
    localparam int N_RANDOM    = 400;
    localparam int TAIL_CYCLES = 40;

    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [SAT_W-1:0]  saturation;
        logic [BYTE_W-1:0] brightness;
    } t_hsv;

    typedef struct packed {
        logic [BYTE_W-1:0] r;
        logic [BYTE_W-1:0] g;
        logic [BYTE_W-1:0] b;
        logic              typed;
        t_hsv              want;
    } t_pixel_row;

    logic              i_clk   = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              start   = 1'b0;
    logic              busy;
    logic [BYTE_W-1:0] i_red   = '0;
    logic [BYTE_W-1:0] i_green = '0;
    logic [BYTE_W-1:0] i_blue  = '0;
    logic              o_done;
    logic [HUE_W-1:0]  o_hue;
    logic [SAT_W-1:0]  o_saturation;
    logic [BYTE_W-1:0] o_brightness;

    t_hsv pending_hsv[$];
    t_hsv oldest;
    int   err_count = 0;

    t_pixel_row directed_rows [N_DIRECTED] = '{
        '{8'd0,   8'd0,   8'd0,   1'b1, '{15'd0,     16'd0,     8'd0}},
        '{8'd255, 8'd255, 8'd255, 1'b1, '{15'd0,     16'd0,     8'd255}},
        '{8'd128, 8'd128, 8'd128, 1'b1, '{15'd0,     16'd0,     8'd128}},
        '{8'd1,   8'd1,   8'd1,   1'b1, '{15'd0,     16'd0,     8'd1}},
        '{8'd255, 8'd0,   8'd0,   1'b1, '{15'd0,     16'd32768, 8'd255}},
        '{8'd0,   8'd255, 8'd0,   1'b1, '{15'd7680,  16'd32768, 8'd255}},
        '{8'd0,   8'd0,   8'd255, 1'b1, '{15'd15360, 16'd32768, 8'd255}},
        '{8'd1,   8'd0,   8'd0,   1'b1, '{15'd0,     16'd32768, 8'd1}},
        '{8'd255, 8'd255, 8'd0,   1'b0, '{15'd0,     16'd0,     8'd0}},
        '{8'd0,   8'd255, 8'd255, 1'b0, '{15'd0,     16'd0,     8'd0}},
        '{8'd255, 8'd0,   8'd255, 1'b0, '{15'd0,     16'd0,     8'd0}},
        '{8'd255, 8'd254, 8'd254, 1'b0, '{15'd0,     16'd0,     8'd0}},
        '{8'd0,   8'd0,   8'd1,   1'b0, '{15'd0,     16'd0,     8'd0}},
        '{8'd255, 8'd0,   8'd1,   1'b0, '{15'd0,     16'd0,     8'd0}},
        '{8'd254, 8'd255, 8'd0,   1'b0, '{15'd0,     16'd0,     8'd0}},
        '{8'd0,   8'd1,   8'd255, 1'b0, '{15'd0,     16'd0,     8'd0}},
        '{8'd1,   8'd0,   8'd255, 1'b0, '{15'd0,     16'd0,     8'd0}},
        '{8'd170, 8'd85,  8'd0,   1'b0, '{15'd0,     16'd0,     8'd0}},
        '{8'd170, 8'd85,  8'd255, 1'b0, '{15'd0,     16'd0,     8'd0}},
        '{8'd127, 8'd128, 8'd1,   1'b0, '{15'd0,     16'd0,     8'd0}},
        '{8'd85,  8'd170, 8'd15,  1'b0, '{15'd0,     16'd0,     8'd0}}
    };

    rgb_to_hsv_pixel #(.HUE_FRAC_BITS(HUE_FRAC)) dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_red        (i_red),
        .i_green      (i_green),
        .i_blue       (i_blue),
        .o_done       (o_done),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_brightness (o_brightness)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic t_hsv convert_pixel(input logic [BYTE_W-1:0] r, g, b);
        logic [BYTE_W-1:0] top;
        logic [BYTE_W-1:0] bottom;
        logic [BYTE_W-1:0] spread;
        logic [63:0]       num;
        logic [63:0]       hue;
        logic [63:0]       sat;
        t_hsv              res;
        top = r;
        if (g > top) top = g;
        if (b > top) top = b;
        bottom = r;
        if (g < bottom) bottom = g;
        if (b < bottom) bottom = b;
        spread = top - bottom;
        hue = 64'd0;
        sat = 64'd0;
        if (spread != 0) begin
            // tie on the maximum goes to red, then green
            if (top == r) num = 64'(g) + 64'd6 * 64'(spread) - 64'(b);
            else if (top == g) num = 64'(b) + 64'd2 * 64'(spread) - 64'(r);
            else num = 64'(r) + 64'd4 * 64'(spread) - 64'(g);
            hue = (64'd60 * (64'd1 << HUE_FRAC) * num) / 64'(spread);
            hue = hue % (64'd360 * (64'd1 << HUE_FRAC));
        end
        if (top != 0) sat = (64'(spread) << SAT_SHIFT) / 64'(top);
        res.hue        = hue[HUE_W-1:0];
        res.saturation = sat[SAT_W-1:0];
        res.brightness = top;
        return res;
    endfunction

    task automatic send_pixel(input logic [BYTE_W-1:0] r, g, b, input logic typed,
                              input t_hsv want, input int gap);
        start   <= 1'b1;
        i_red   <= r;
        i_green <= g;
        i_blue  <= b;
        do @(posedge i_clk); while (busy);
        pending_hsv.push_back(typed ? want : convert_pixel(r, g, b));
        if (gap > 0) begin
            start   <= 1'b0;
            i_red   <= BYTE_W'($urandom);
            i_green <= BYTE_W'($urandom);
            i_blue  <= BYTE_W'($urandom);
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic wait_results_drained();
        while (pending_hsv.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_done) begin
            if (pending_hsv.size() == 0) begin
                $error("unexpected result: hue %0d saturation %0d brightness %0d",
                       o_hue, o_saturation, o_brightness);
                err_count++;
            end else begin
                oldest = pending_hsv.pop_front();
                if (o_hue !== oldest.hue) begin
                    $error("hue: expected %0d, got %0d", oldest.hue, o_hue);
                    err_count++;
                end
                if (o_saturation !== oldest.saturation) begin
                    $error("saturation: expected %0d, got %0d",
                           oldest.saturation, o_saturation);
                    err_count++;
                end
                if (o_brightness !== oldest.brightness) begin
                    $error("brightness: expected %0d, got %0d",
                           oldest.brightness, o_brightness);
                    err_count++;
                end
            end
        end
    end

    initial begin
        #500000;
        $display("tb_rgb_to_hsv_pixel: errors");
        $finish;
    end

    initial begin
        logic [BYTE_W-1:0] r, g, b, v;
        int                gap;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int i = 0; i < N_DIRECTED; i++) begin
            send_pixel(directed_rows[i].r, directed_rows[i].g, directed_rows[i].b,
                       directed_rows[i].typed, directed_rows[i].want,
                       $urandom_range(0, 4));
        end
        start <= 1'b0;
        wait_results_drained();

        for (int i = 0; i < N_RANDOM; i++) begin
            r = BYTE_W'($urandom);
            g = BYTE_W'($urandom);
            b = BYTE_W'($urandom);
            case ($urandom_range(0, 9))
                0: begin
                    g = r;
                    b = r;
                end
                1: begin
                    v = BYTE_W'($urandom);
                    case ($urandom_range(0, 3))
                        0: begin r = v; g = v; b = BYTE_W'($urandom_range(0, v)); end
                        1: begin g = v; b = v; r = BYTE_W'($urandom_range(0, v)); end
                        2: begin r = v; b = v; g = BYTE_W'($urandom_range(0, v)); end
                        default: begin r = v; g = v; b = v; end
                    endcase
                end
                2: begin
                    if ($urandom_range(0, 1)) r = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    if ($urandom_range(0, 1)) g = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                    if ($urandom_range(0, 1)) b = $urandom_range(0, 1) ? 8'd255 : 8'd0;
                end
                default: ;
            endcase
            // back-to-back stretch with no gaps
            gap = (i >= 100 && i < 160) ? 0 : $urandom_range(0, 4);
            send_pixel(r, g, b, 1'b0, '0, gap);
            if (i == 250) begin
                start <= 1'b0;
                wait_results_drained();
            end
        end
        start <= 1'b0;

        wait_results_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (err_count == 0) begin
            $display("tb_rgb_to_hsv_pixel: clean");
        end else begin
            $display("tb_rgb_to_hsv_pixel: errors");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
design/rgbhsv_pkg.sv
design/rgbhsv_front.sv
design/rgbhsv_queue.sv
design/rgbhsv_div.sv
design/rgbhsv_back.sv
design/rgb_to_hsv_pixel.sv
tb/tb_rgb_to_hsv_pixel.sv
